FILE: sv/sha1_pkg.sv
package sha1_pkg;

   localparam int LEN_COUNT_BITS_DEF = 61;

   localparam int WORD_BITS  = 32;
   localparam int BLOCK_BITS = 512;
   localparam int CSR_IDX_BITS = 3;
   localparam int ROUND_BITS = 7;

   localparam logic [ROUND_BITS-1:0] LAST_ROUND   = 7'd79;
   localparam logic [ROUND_BITS-1:0] PHASE1_START = 7'd20;
   localparam logic [ROUND_BITS-1:0] PHASE2_START = 7'd40;
   localparam logic [ROUND_BITS-1:0] PHASE3_START = 7'd60;

   localparam logic [5:0] POS_LAST     = 6'd63;
   localparam logic [5:0] POS_LEN_BASE = 6'd56;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [CSR_IDX_BITS-1:0] REG_INIT_H0 = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_INIT_H1 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_INIT_H2 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_INIT_H3 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_INIT_H4 = 3'd4;

   localparam logic [31:0] INIT_H0_RST = 32'h67452301;
   localparam logic [31:0] INIT_H1_RST = 32'hEFCDAB89;
   localparam logic [31:0] INIT_H2_RST = 32'h98BADCFE;
   localparam logic [31:0] INIT_H3_RST = 32'h10325476;
   localparam logic [31:0] INIT_H4_RST = 32'hC3D2E1F0;

   localparam logic [31:0] K_PHASE0 = 32'h5A827999;
   localparam logic [31:0] K_PHASE1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_PHASE2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_PHASE3 = 32'hCA62C1D6;

   typedef enum logic [1:0] {
      BSEL_MSG,
      BSEL_MARK,
      BSEL_ZERO,
      BSEL_LEN
   } bsel_type;

   typedef enum logic [1:0] {
      PH_CHOOSE,
      PH_PARITY1,
      PH_MAJORITY,
      PH_PARITY2
   } phase_type;

   typedef struct packed {
      logic      byte_push;
      bsel_type  byte_sel;
      logic [2:0] len_idx;
      logic      cnt_inc;
      logic      cnt_clear;
      logic      chain_load;
      logic      work_load;
      logic      round_en;
      phase_type phase;
      logic      chain_add;
      logic      dig_load;
   } cmd_type;

   function automatic logic [31:0] round_f(input phase_type ph, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] res;
      case (ph)
         PH_CHOOSE:   res = (b & c) | (~b & d);
         PH_MAJORITY: res = (b & c) | (b & d) | (c & d);
         default:     res = b ^ c ^ d;
      endcase
      return res;
   endfunction

   function automatic logic [31:0] round_k(input phase_type ph);
      logic [31:0] res;
      case (ph)
         PH_CHOOSE:   res = K_PHASE0;
         PH_PARITY1:  res = K_PHASE1;
         PH_MAJORITY: res = K_PHASE2;
         default:     res = K_PHASE3;
      endcase
      return res;
   endfunction

endpackage

FILE: sv/sha1_ctrl.sv
module sha1_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_last_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sha1_pkg::cmd_type cmd
);
   import sha1_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [5:0]            pos_ff, pos_in;
   logic [ROUND_BITS-1:0] rnd_ff, rnd_in;
   logic                  active_ff, active_in;
   logic                  last_ff, last_in;
   logic                  first_ff, first_in;
   logic                  len_ok_ff, len_ok_in;
   logic                  fin_ff, fin_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      rnd_in       = rnd_ff;
      active_in    = active_ff;
      last_in      = last_ff;
      first_in     = first_ff;
      len_ok_in    = len_ok_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.len_idx  = pos_ff[2:0];
      if (rnd_ff < PHASE1_START) begin
         cmd.phase = PH_CHOOSE;
      end else if (rnd_ff < PHASE2_START) begin
         cmd.phase = PH_PARITY1;
      end else if (rnd_ff < PHASE3_START) begin
         cmd.phase = PH_MAJORITY;
      end else begin
         cmd.phase = PH_PARITY2;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.byte_push  = 1'b1;
               cmd.byte_sel   = BSEL_MSG;
               cmd.cnt_inc    = 1'b1;
               cmd.chain_load = ~active_ff;
               active_in      = 1'b1;
               pos_in         = pos_ff + 6'd1;
               last_in        = req_last_byte;
               first_in       = req_last_byte;
               fin_in         = 1'b0;
               if (pos_ff == POS_LAST) begin
                  state_in = ST_LOAD;
               end else if (req_last_byte) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.work_load = 1'b1;
            rnd_in        = '0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            rnd_in       = rnd_ff + 7'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.chain_add = 1'b1;
            if (fin_ff) begin
               state_in = ST_DONE;
            end else if (last_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            cmd.byte_push = 1'b1;
            if (first_ff) begin
               cmd.byte_sel = BSEL_MARK;
               len_ok_in    = (pos_ff < POS_LEN_BASE);
            end else if (len_ok_ff && (pos_ff >= POS_LEN_BASE)) begin
               cmd.byte_sel = BSEL_LEN;
            end else begin
               cmd.byte_sel = BSEL_ZERO;
            end
            first_in = 1'b0;
            pos_in   = pos_ff + 6'd1;
            if (pos_ff == POS_LAST) begin
               fin_in    = ~first_ff & len_ok_ff;
               len_ok_in = 1'b1;
               state_in  = ST_LOAD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.dig_load  = 1'b1;
               cmd.cnt_clear = 1'b1;
               rsp_valid_in  = 1'b1;
               active_in     = 1'b0;
               last_in       = 1'b0;
               fin_in        = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         rnd_ff       <= '0;
         active_ff    <= 1'b0;
         last_ff      <= 1'b0;
         first_ff     <= 1'b0;
         len_ok_ff    <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rnd_ff       <= rnd_in;
         active_ff    <= active_in;
         last_ff      <= last_in;
         first_ff     <= first_in;
         len_ok_ff    <= len_ok_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/sha1_dpath.sv
module sha1_dpath #(
   parameter int LEN_COUNT_BITS = sha1_pkg::LEN_COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sha1_pkg::cmd_type                 cmd,
   input  logic [7:0]                        req_msg_byte,
   input  logic                              csr_wr_en,
   input  logic [sha1_pkg::CSR_IDX_BITS-1:0] csr_addr,
   input  logic [31:0]                       csr_wr_data,
   output logic [31:0]                       rsp_digest_w0,
   output logic [31:0]                       rsp_digest_w1,
   output logic [31:0]                       rsp_digest_w2,
   output logic [31:0]                       rsp_digest_w3,
   output logic [31:0]                       rsp_digest_w4
);
   import sha1_pkg::*;

   logic [31:0]               init_ff [5];
   logic [31:0]               chain_ff [5];
   logic [31:0]               dig_ff [5];
   logic [BLOCK_BITS-1:0]     blk_ff;
   logic [31:0]               a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [LEN_COUNT_BITS-1:0] cnt_ff;

   logic [63:0] len_ext;
   logic [63:0] len_bits;
   logic [5:0]  len_lsb;
   logic [7:0]  push_byte;
   logic [31:0] w_cur;
   logic [31:0] w_mix;
   logic [31:0] w_next;
   logic [31:0] t_sum;

   assign len_ext  = 64'(cnt_ff);
   assign len_bits = {len_ext[60:0], 3'b000};
   assign len_lsb  = {3'(3'd7 - cmd.len_idx), 3'b000};

   always_comb begin
      case (cmd.byte_sel)
         BSEL_MSG:  push_byte = req_msg_byte;
         BSEL_MARK: push_byte = PAD_MARK;
         BSEL_LEN:  push_byte = len_bits[len_lsb +: 8];
         default:   push_byte = 8'h00;
      endcase
   end

   // The window holds sixteen schedule words, the oldest at the top.
   assign w_cur  = blk_ff[511:480];
   assign w_mix  = blk_ff[95:64] ^ blk_ff[255:224] ^ blk_ff[447:416] ^ blk_ff[511:480];
   assign w_next = {w_mix[30:0], w_mix[31]};
   assign t_sum  = {a_ff[26:0], a_ff[31:27]} + round_f(cmd.phase, b_ff, c_ff, d_ff)
                   + e_ff + w_cur + round_k(cmd.phase);

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff[0] <= INIT_H0_RST;
         init_ff[1] <= INIT_H1_RST;
         init_ff[2] <= INIT_H2_RST;
         init_ff[3] <= INIT_H3_RST;
         init_ff[4] <= INIT_H4_RST;
      end else if (csr_wr_en) begin
         case (csr_addr)
            REG_INIT_H0: init_ff[0] <= csr_wr_data;
            REG_INIT_H1: init_ff[1] <= csr_wr_data;
            REG_INIT_H2: init_ff[2] <= csr_wr_data;
            REG_INIT_H3: init_ff[3] <= csr_wr_data;
            REG_INIT_H4: init_ff[4] <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_clear) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.byte_push) begin
         blk_ff <= {blk_ff[BLOCK_BITS-9:0], push_byte};
      end else if (cmd.round_en) begin
         blk_ff <= {blk_ff[BLOCK_BITS-33:0], w_next};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.work_load) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (cmd.round_en) begin
         a_ff <= t_sum;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.chain_load) begin
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= init_ff[i];
         end
      end else if (cmd.chain_add) begin
         chain_ff[0] <= chain_ff[0] + a_ff;
         chain_ff[1] <= chain_ff[1] + b_ff;
         chain_ff[2] <= chain_ff[2] + c_ff;
         chain_ff[3] <= chain_ff[3] + d_ff;
         chain_ff[4] <= chain_ff[4] + e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dig_load) begin
         for (int i = 0; i < 5; i++) begin
            dig_ff[i] <= chain_ff[i];
         end
      end
   end

   assign rsp_digest_w0 = dig_ff[0];
   assign rsp_digest_w1 = dig_ff[1];
   assign rsp_digest_w2 = dig_ff[2];
   assign rsp_digest_w3 = dig_ff[3];
   assign rsp_digest_w4 = dig_ff[4];

endmodule

FILE: sv/sha1_hash_engine_unit.sv
// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_ready     req_msg_byte, req_last_byte
// rsp       out        rsp_valid / rsp_ready     rsp_digest_w0 .. rsp_digest_w4
// csr       in         csr_wr_en                 csr_addr, csr_wr_data
//
// A request byte is taken in the idle state; every 64th byte then holds the input
// while the round unit runs its 80 rounds at one per cycle, plus load and add.
// A final byte is followed by the padding bytes, pushed one per cycle, and one or two
// such compressions before the digest is registered. Reset is synchronous, clears the
// control state and the byte count and loads the init registers with their reset
// values; the digest register holds until taken, and the next message proceeds until
// its own digest is ready.
module sha1_hash_engine_unit #(
   parameter int LEN_COUNT_BITS = sha1_pkg::LEN_COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_msg_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [31:0]                       rsp_digest_w0,
   output logic [31:0]                       rsp_digest_w1,
   output logic [31:0]                       rsp_digest_w2,
   output logic [31:0]                       rsp_digest_w3,
   output logic [31:0]                       rsp_digest_w4,
   input  logic                              csr_wr_en,
   input  logic [sha1_pkg::CSR_IDX_BITS-1:0] csr_addr,
   input  logic [31:0]                       csr_wr_data
);
   import sha1_pkg::*;

   cmd_type cmd;

   sha1_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd)
   );

   sha1_dpath #(
      .LEN_COUNT_BITS (LEN_COUNT_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_msg_byte  (req_msg_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_addr      (csr_addr),
      .csr_wr_data   (csr_wr_data),
      .rsp_digest_w0 (rsp_digest_w0),
      .rsp_digest_w1 (rsp_digest_w1),
      .rsp_digest_w2 (rsp_digest_w2),
      .rsp_digest_w3 (rsp_digest_w3),
      .rsp_digest_w4 (rsp_digest_w4)
   );

`ifndef ASSERT_OFF
   a_no_req_in_rounds: assert property (@(posedge clock) disable iff (reset)
      cmd.round_en |-> !req_ready)
      else $error("request channel open while rounds run");

   a_push_not_round: assert property (@(posedge clock) disable iff (reset)
      cmd.byte_push |-> !cmd.round_en && !cmd.chain_add)
      else $error("byte pushed during compression");

   a_digest_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.dig_load |=> rsp_valid)
      else $error("digest loaded without response valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.dig_load |-> !rsp_valid || rsp_ready)
      else $error("digest overwritten before it was taken");
`endif

endmodule
